/* rtl/stc_pkg.sv */
`timescale 1ns / 1ps

package stc_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int VOL_W     = 6;
   localparam int GAIN_W    = 5;
   localparam int TPS_W     = 18;
   localparam int SEC_W     = 6;
   localparam int MIN_W     = 8;
   localparam int ACC_W     = 32;
   localparam int LPMIX_W   = 14;
   localparam int HPSUM_W   = 18;

   localparam logic signed [SAMPLE_W-1:0] LP_IN_COEF = 16'sd2268;
   localparam logic signed [SAMPLE_W-1:0] LP_FB_COEF = 16'sd30500;
   localparam logic signed [ACC_W-1:0]    CLAMP_HI   = 32'sd32766;
   localparam logic signed [ACC_W-1:0]    CLAMP_LO   = -32'sd32766;
   localparam logic [SEC_W-1:0]           SECS_PER_MIN = 6'd60;
   localparam logic [MIN_W-1:0]           MINUTES_MAX  = 8'd255;
   localparam logic [VOL_W-1:0]           VOLUME_RST   = 6'd8;
   localparam logic [TPS_W-1:0]           TPS_RST      = 18'd88200;

   typedef enum logic [1:0] {
      CSR_VOLUME,
      CSR_BASS_GAIN,
      CSR_TREBLE_GAIN,
      CSR_TICKS_PER_SECOND
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] raw_sample;
      logic                       active;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] dac_word;
      logic                is_left;
      logic [SEC_W-1:0]    play_seconds;
      logic [MIN_W-1:0]    play_minutes;
   } rsp_type;

   typedef struct packed {
      logic enable;
      logic clear;
   } mac_ctl_type;

endpackage

/* rtl/stc_mac.sv */
`timescale 1ns / 1ps

module stc_mac (
   input  logic                                 clock,
   input  stc_pkg::mac_ctl_type                 ctl,
   input  logic signed [stc_pkg::SAMPLE_W-1:0]  op_a,
   input  logic signed [stc_pkg::SAMPLE_W-1:0]  op_b,
   input  logic signed [stc_pkg::ACC_W-1:0]     addend,
   output logic signed [stc_pkg::ACC_W-1:0]     acc
);
   import stc_pkg::*;

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] product;

   assign product = op_a * op_b;
   assign acc_in  = (ctl.clear ? addend : acc_ff) + product;
   assign acc     = acc_ff;

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         acc_ff <= acc_in;
      end
   end

endmodule

/* rtl/stereo_tone_control_output.sv */
// Stereo bass/treble tone control with one-bit-late DAC framing and a playback
// clock. Requests carry interleaved samples, left first. An active request runs
// five multiply-accumulate steps through one shared 16x16 MAC unit. Its result is
// loaded from the finish state after the last step, and waits there while the
// output register holds an untaken result; the block takes a new request only in
// idle. An inactive request goes straight to the finish state and loads a zero
// word with the held time. The block accepts one request at a time; a loaded
// result may wait in the output register while the next request is taken.
// Configuration writes are accepted every cycle and belong to idle periods only.
`timescale 1ns / 1ps

module stereo_tone_control_output (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  stc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output stc_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  stc_pkg::csr_index_type         csr_index,
   input  logic [stc_pkg::TPS_W-1:0]      csr_data
);
   import stc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VOL,
      ST_LP_IN,
      ST_LP_FB,
      ST_BASS,
      ST_TREBLE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] s_ff, s_in;
   logic signed [LPMIX_W-1:0]  hp_mix_ff, hp_mix_in;
   logic                       active_ff, active_in;
   logic                       left_ff, left_in;
   logic                       toggle_ff, toggle_in;
   logic                       carry_ff, carry_in;
   logic signed [SAMPLE_W-1:0] lp_left_ff, lp_left_in, lp_right_ff, lp_right_in;
   logic signed [SAMPLE_W-1:0] hp_left_ff, hp_left_in, hp_right_ff, hp_right_in;
   logic signed [SAMPLE_W-1:0] in_left_ff, in_left_in, in_right_ff, in_right_in;
   logic [TPS_W-1:0]           tick_ff, tick_in;
   logic [SEC_W-1:0]           sec_ff, sec_in;
   logic [MIN_W-1:0]           min_ff, min_in;
   logic [VOL_W-1:0]           volume_ff, volume_in;
   logic signed [GAIN_W-1:0]   bass_ff, bass_in;
   logic signed [GAIN_W-1:0]   treble_ff, treble_in;
   logic [TPS_W-1:0]           tps_ff, tps_in;
   rsp_type                    rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   mac_ctl_type                mac_ctl;
   logic signed [SAMPLE_W-1:0] mac_a, mac_b;
   logic signed [ACC_W-1:0]    mac_addend;
   logic signed [ACC_W-1:0]    acc;

   logic signed [SAMPLE_W-1:0] s_w;
   logic signed [LPMIX_W-1:0]  lp_mix;
   logic signed [SAMPLE_W-1:0] lp_sel, hp_sel, in_sel;
   logic signed [HPSUM_W-1:0]  hp_sum;
   logic signed [ACC_W-1:0]    mix_clamped;
   logic [SAMPLE_W-1:0]        m16;
   logic [TPS_W-1:0]           tick_next;
   logic [SEC_W-1:0]           sec_next;

   stc_mac u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .op_a   (mac_a),
      .op_b   (mac_b),
      .addend (mac_addend),
      .acc    (acc)
   );

   assign s_w    = acc[20:5];
   assign lp_mix = acc[31:18];
   assign lp_sel = left_ff ? lp_left_ff : lp_right_ff;
   assign hp_sel = left_ff ? hp_left_ff : hp_right_ff;
   assign in_sel = left_ff ? in_left_ff : in_right_ff;
   assign hp_sum = {{2{s_ff[SAMPLE_W-1]}}, s_ff} - {{2{in_sel[SAMPLE_W-1]}}, in_sel}
                 + {{2{hp_sel[SAMPLE_W-1]}}, hp_sel};

   assign mix_clamped = (acc > CLAMP_HI) ? CLAMP_HI : ((acc < CLAMP_LO) ? CLAMP_LO : acc);
   assign m16         = mix_clamped[SAMPLE_W-1:0];
   assign tick_next   = tick_ff + 1'b1;
   assign sec_next    = sec_ff + 1'b1;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      s_in         = s_ff;
      hp_mix_in    = hp_mix_ff;
      active_in    = active_ff;
      left_in      = left_ff;
      toggle_in    = toggle_ff;
      carry_in     = carry_ff;
      lp_left_in   = lp_left_ff;
      lp_right_in  = lp_right_ff;
      hp_left_in   = hp_left_ff;
      hp_right_in  = hp_right_ff;
      in_left_in   = in_left_ff;
      in_right_in  = in_right_ff;
      tick_in      = tick_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      volume_in    = volume_ff;
      bass_in      = bass_ff;
      treble_in    = treble_ff;
      tps_in       = tps_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mac_ctl      = '{enable: 1'b0, clear: 1'b0};
      mac_a        = x_ff;
      mac_b        = {{(SAMPLE_W-VOL_W){1'b0}}, volume_ff};
      mac_addend   = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_VOLUME:           volume_in = csr_data[VOL_W-1:0];
            CSR_BASS_GAIN:        bass_in   = csr_data[GAIN_W-1:0];
            CSR_TREBLE_GAIN:      treble_in = csr_data[GAIN_W-1:0];
            CSR_TICKS_PER_SECOND: tps_in    = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in      = req_data.raw_sample;
               active_in = req_data.active;
               if (req_data.active) begin
                  toggle_in = !toggle_ff;
                  left_in   = !toggle_ff;
                  state_in  = ST_VOL;
               end else begin
                  state_in  = ST_DONE;
               end
            end
         end
         ST_VOL: begin
            mac_ctl  = '{enable: 1'b1, clear: 1'b1};
            state_in = ST_LP_IN;
         end
         ST_LP_IN: begin
            s_in     = s_w;
            mac_ctl  = '{enable: 1'b1, clear: 1'b1};
            mac_a    = s_w;
            mac_b    = LP_IN_COEF;
            state_in = ST_LP_FB;
         end
         ST_LP_FB: begin
            mac_ctl  = '{enable: 1'b1, clear: 1'b0};
            mac_a    = lp_sel;
            mac_b    = LP_FB_COEF;
            state_in = ST_BASS;
         end
         ST_BASS: begin
            hp_mix_in = hp_sum[HPSUM_W-1:4];
            if (left_ff) begin
               lp_left_in  = acc[30:15];
               hp_left_in  = hp_sum[16:1];
               in_left_in  = s_ff;
            end else begin
               lp_right_in = acc[30:15];
               hp_right_in = hp_sum[16:1];
               in_right_in = s_ff;
            end
            mac_ctl    = '{enable: 1'b1, clear: 1'b1};
            mac_a      = {{(SAMPLE_W-LPMIX_W){lp_mix[LPMIX_W-1]}}, lp_mix};
            mac_b      = {{(SAMPLE_W-GAIN_W){bass_ff[GAIN_W-1]}}, bass_ff};
            mac_addend = {{(ACC_W-SAMPLE_W){s_ff[SAMPLE_W-1]}}, s_ff};
            state_in   = ST_TREBLE;
         end
         ST_TREBLE: begin
            mac_ctl  = '{enable: 1'b1, clear: 1'b0};
            mac_a    = {{(SAMPLE_W-LPMIX_W){hp_mix_ff[LPMIX_W-1]}}, hp_mix_ff};
            mac_b    = {{(SAMPLE_W-GAIN_W){treble_ff[GAIN_W-1]}}, treble_ff};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (active_ff) begin
                  rsp_in.dac_word = {carry_ff, m16[SAMPLE_W-1:1]};
                  rsp_in.is_left  = left_ff;
                  carry_in        = m16[0];
                  rsp_in.play_seconds = sec_ff;
                  rsp_in.play_minutes = min_ff;
                  tick_in = tick_next;
                  if (tick_next >= tps_ff) begin
                     tick_in = '0;
                     if (sec_next >= SECS_PER_MIN) begin
                        sec_in = '0;
                        rsp_in.play_seconds = '0;
                        if (min_ff != MINUTES_MAX) begin
                           min_in = min_ff + 1'b1;
                           rsp_in.play_minutes = min_ff + 1'b1;
                        end
                     end else begin
                        sec_in = sec_next;
                        rsp_in.play_seconds = sec_next;
                     end
                  end
               end else begin
                  rsp_in.dac_word     = '0;
                  rsp_in.is_left      = 1'b0;
                  rsp_in.play_seconds = sec_ff;
                  rsp_in.play_minutes = min_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      s_ff      <= s_in;
      hp_mix_ff <= hp_mix_in;
      active_ff <= active_in;
      left_ff   <= left_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         toggle_ff    <= 1'b0;
         carry_ff     <= 1'b0;
         lp_left_ff   <= '0;
         lp_right_ff  <= '0;
         hp_left_ff   <= '0;
         hp_right_ff  <= '0;
         in_left_ff   <= '0;
         in_right_ff  <= '0;
         tick_ff      <= '0;
         sec_ff       <= '0;
         min_ff       <= '0;
         volume_ff    <= VOLUME_RST;
         bass_ff      <= '0;
         treble_ff    <= '0;
         tps_ff       <= TPS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         toggle_ff    <= toggle_in;
         carry_ff     <= carry_in;
         lp_left_ff   <= lp_left_in;
         lp_right_ff  <= lp_right_in;
         hp_left_ff   <= hp_left_in;
         hp_right_ff  <= hp_right_in;
         in_left_ff   <= in_left_in;
         in_right_ff  <= in_right_in;
         tick_ff      <= tick_in;
         sec_ff       <= sec_in;
         min_ff       <= min_in;
         volume_ff    <= volume_in;
         bass_ff      <= bass_in;
         treble_ff    <= treble_in;
         tps_ff       <= tps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_seconds_range: assert property (@(posedge clock) disable iff (reset)
      sec_ff < SECS_PER_MIN)
      else $error("seconds out of range");

   a_minutes_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> min_ff >= $past(min_ff))
      else $error("minutes went backward");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_done_loads_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && state_in == ST_IDLE |=> rsp_valid_ff)
      else $error("finished request without a result");
`endif

endmodule
